>>> rtl/dq_pkg.sv
// Shared constants, types and helpers for the double-ended queue.
`default_nettype none

package dq_pkg;

	// ring store size and derived widths
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QA_W   = $clog2(QDEPTH);
	localparam int QC_W   = $clog2(QDEPTH + 1);

	// func codes on the input port
	localparam logic [3:0] FN_PUSH_FRONT = 4'd0;
	localparam logic [3:0] FN_PUSH_BACK  = 4'd1;
	localparam logic [3:0] FN_POP_FRONT  = 4'd2;
	localparam logic [3:0] FN_POP_BACK   = 4'd3;
	localparam logic [3:0] FN_READ_FRONT = 4'd4;
	localparam logic [3:0] FN_READ_BACK  = 4'd5;
	localparam logic [3:0] FN_LIST       = 4'd6;
	localparam logic [3:0] FN_CLEAR      = 4'd7;
	localparam logic [3:0] FN_REVERSE    = 4'd8;
	localparam logic [3:0] FN_SORT       = 4'd9;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_READ_FRONT,
		OP_READ_BACK,
		OP_LIST,
		OP_CLEAR,
		OP_REVERSE,
		OP_SORT
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic [4:0]  count;
		logic        is_empty;
		logic        last;
	} res_t;

	// fold an internal count onto the 5-bit count field
	function automatic logic [4:0] count5(input logic [CNT_W-1:0] c);
		logic [31:0] w;
		begin
			w = 32'(c);
			return w[4:0];
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/dq_front.sv
// Front end: takes the start handshake and classifies func into an operation.
`default_nettype none

module dq_front (
	input  wire logic         start,
	input  wire logic [3:0]   func,
	input  wire logic [31:0]  value,
	input  wire logic         q_full,
	output logic              busy,
	output logic              push,
	output dq_pkg::cmd_t      cmd
);
	import dq_pkg::*;

	op_t op;

	always_comb begin
		case (func)
			FN_PUSH_FRONT: op = OP_PUSH_FRONT;
			FN_PUSH_BACK:  op = OP_PUSH_BACK;
			FN_POP_FRONT:  op = OP_POP_FRONT;
			FN_POP_BACK:   op = OP_POP_BACK;
			FN_READ_FRONT: op = OP_READ_FRONT;
			FN_READ_BACK:  op = OP_READ_BACK;
			FN_LIST:       op = OP_LIST;
			FN_CLEAR:      op = OP_CLEAR;
			FN_REVERSE:    op = OP_REVERSE;
			FN_SORT:       op = OP_SORT;
			default:       op = OP_NOP;
		endcase
	end

	assign busy      = q_full;
	assign push      = start & ~q_full;
	assign cmd.op    = op;
	assign cmd.value = value;

endmodule

`default_nettype wire

>>> rtl/dq_cmdq.sv
// Small command queue that decouples the front end from the back end.
`default_nettype none

module dq_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dq_pkg::cmd_t  cmd_in,
	input  wire logic          pop,
	output logic               valid,
	output logic               full,
	output dq_pkg::cmd_t       cmd_out
);
	import dq_pkg::*;

	cmd_t            entry_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] fill_q;

	logic do_push;
	logic do_pop;

	assign valid   = (fill_q != '0);
	assign full    = (fill_q == QC_W'(QDEPTH));
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;
	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QA_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QA_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QC_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QC_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/dq_back.sv
// Back end: ring store, head/count/direction state and the operation sequencer.
`default_nettype none

module dq_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire dq_pkg::cmd_t  cmd,
	output logic               pop,
	output logic               strobe,
	output dq_pkg::res_t       res
);
	import dq_pkg::*;

	localparam int SUM_W = IDX_W + 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RDOUT = 7'b0000010,
		S_LIST  = 7'b0000100,
		S_SRD0  = 7'b0001000,
		S_SRD1  = 7'b0010000,
		S_SCMP  = 7'b0100000,
		S_SEND  = 7'b1000000
	} state_t;

	// (a + b) mod DEPTH, with a < DEPTH and b < DEPTH
	function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
	                                              input logic [CNT_W-1:0] b);
		logic [SUM_W-1:0] s;
		begin
			s = SUM_W'(a) + SUM_W'(b);
			if (s >= SUM_W'(DEPTH)) begin
				s = s - SUM_W'(DEPTH);
			end
			return s[IDX_W-1:0];
		end
	endfunction

	// store address of logical position i (0 = front)
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
	                                           input logic [CNT_W-1:0] cnt,
	                                           input logic             flip,
	                                           input logic [CNT_W-1:0] i);
		logic [CNT_W-1:0] off;
		begin
			off = flip ? (cnt - CNT_W'(1) - i) : i;
			return add_mod(head, off);
		end
	endfunction

	logic [31:0]      slots [DEPTH];
	logic [31:0]      rdata_q;

	state_t           state_q, state_n;
	logic [IDX_W-1:0] head_q, head_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             flip_q, flip_n;
	logic [CNT_W-1:0] idx_q, idx_n;
	logic [CNT_W-1:0] len_q, len_n;
	logic [31:0]      carry_q, carry_n;
	logic             last_q, last_n;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_data;

	logic             emit;
	logic [31:0]      e_value;
	logic [1:0]       e_status;
	logic             e_last;

	logic             strobe_q;
	res_t             res_q;

	logic             full;
	logic             empty;
	logic             front_op;
	logic             at_head;
	logic [IDX_W-1:0] head_m1;
	logic [IDX_W-1:0] head_p1;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_m1  = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
	assign head_p1  = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	assign front_op = (cmd.op == OP_PUSH_FRONT) || (cmd.op == OP_POP_FRONT) ||
	                  (cmd.op == OP_READ_FRONT);
	// the end stored at head_q: front when not flipped, rear when flipped
	assign at_head  = (front_op == ~flip_q);

	always_comb begin
		state_n  = state_q;
		head_n   = head_q;
		cnt_n    = cnt_q;
		flip_n   = flip_q;
		idx_n    = idx_q;
		len_n    = len_q;
		carry_n  = carry_q;
		last_n   = last_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = '0;
		emit     = 1'b0;
		e_value  = '0;
		e_status = ST_OK;
		e_last   = 1'b1;
		pop      = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					case (cmd.op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							emit = 1'b1;
							if (full) begin
								e_status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_data = cmd.value;
								cnt_n   = cnt_q + CNT_W'(1);
								if (at_head) begin
									head_n  = head_m1;
									wr_addr = head_m1;
								end else begin
									wr_addr = add_mod(head_q, cnt_q);
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK, OP_READ_FRONT, OP_READ_BACK: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = at_head ? head_q : add_mod(head_q, cnt_q - CNT_W'(1));
								if (cmd.op == OP_POP_FRONT || cmd.op == OP_POP_BACK) begin
									cnt_n = cnt_q - CNT_W'(1);
									if (at_head) begin
										head_n = head_p1;
									end
								end
								state_n = S_RDOUT;
							end
						end
						OP_LIST: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = phys(head_q, cnt_q, flip_q, '0);
								idx_n   = CNT_W'(1);
								last_n  = (cnt_q == CNT_W'(1));
								state_n = S_LIST;
							end
						end
						OP_CLEAR: begin
							emit   = 1'b1;
							head_n = '0;
							cnt_n  = '0;
							flip_n = 1'b0;
						end
						OP_REVERSE: begin
							emit = 1'b1;
							if (empty) begin
								e_status = ST_EMPTY;
							end else begin
								flip_n = ~flip_q;
							end
						end
						OP_SORT: begin
							if (empty) begin
								emit     = 1'b1;
								e_status = ST_EMPTY;
							end else if (cnt_q == CNT_W'(1)) begin
								emit = 1'b1;
							end else begin
								len_n   = cnt_q;
								state_n = S_SRD0;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_RDOUT: begin
				emit    = 1'b1;
				e_value = rdata_q;
				state_n = S_IDLE;
			end
			S_LIST: begin
				emit    = 1'b1;
				e_value = rdata_q;
				e_last  = last_q;
				if (last_q) begin
					state_n = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, cnt_q, flip_q, idx_q);
					last_n  = (idx_q == cnt_q - CNT_W'(1));
					idx_n   = idx_q + CNT_W'(1);
				end
			end
			// one bubble pass: the larger value rides along in carry_q
			S_SRD0: begin
				rd_en   = 1'b1;
				rd_addr = phys(head_q, cnt_q, flip_q, '0);
				state_n = S_SRD1;
			end
			S_SRD1: begin
				carry_n = rdata_q;
				rd_en   = 1'b1;
				rd_addr = phys(head_q, cnt_q, flip_q, CNT_W'(1));
				idx_n   = '0;
				state_n = S_SCMP;
			end
			S_SCMP: begin
				wr_en   = 1'b1;
				wr_addr = phys(head_q, cnt_q, flip_q, idx_q);
				if ($signed(carry_q) > $signed(rdata_q)) begin
					wr_data = rdata_q;
				end else begin
					wr_data = carry_q;
					carry_n = rdata_q;
				end
				if (idx_q + CNT_W'(1) == len_q - CNT_W'(1)) begin
					state_n = S_SEND;
				end else begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, cnt_q, flip_q, idx_q + CNT_W'(2));
					idx_n   = idx_q + CNT_W'(1);
				end
			end
			S_SEND: begin
				wr_en   = 1'b1;
				wr_addr = phys(head_q, cnt_q, flip_q, len_q - CNT_W'(1));
				wr_data = carry_q;
				len_n   = len_q - CNT_W'(1);
				if (len_q == CNT_W'(2)) begin
					emit    = 1'b1;
					state_n = S_IDLE;
				end else begin
					state_n = S_SRD0;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// ring store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= slots[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_n;
		len_q   <= len_n;
		carry_q <= carry_n;
		last_q  <= last_n;
		if (emit) begin
			res_q.value    <= e_value;
			res_q.status   <= e_status;
			res_q.count    <= count5(cnt_n);
			res_q.is_empty <= (cnt_n == '0);
			res_q.last     <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			cnt_q    <= '0;
			flip_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			head_q   <= head_n;
			cnt_q    <= cnt_n;
			flip_q   <= flip_n;
			strobe_q <= emit;
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// Top level of the double-ended queue: front end, command queue and back end.
`default_nettype none

// Double-ended queue of signed 32-bit words in a ring store of DEPTH entries.
//
// Input: a word (func, value) is taken at a rising edge with start high and
// busy low. busy rises only when the two-entry command queue is full.
// Output: each result sits on the result ports for one cycle with strobe
// high; the receiver cannot hold results off, so none is ever stalled.
//
// Path of a word: it is written into the command queue, the back end takes it
// from there and registers its result; pop, read and list add the registered
// store read in between. Steps of the back-end sequencer and its store:
//   push, clear, reverse, unused codes, any operation on empty: idle state only
//   pop and read: idle, then S_RDOUT (registered store read)
//   list of n entries: one result per cycle, last on the final
//   sort of n >= 2 entries: bubble passes of length L = n..2, each through
//   S_SRD0, S_SRD1, S_SCMP per pair and S_SEND; one entry: idle state only
// The front end keeps taking words while the back end works, until the
// queue fills.
//
// Reset (arst_n low, asynchronous): empty deque, head at zero, normal
// direction, command queue empty, no strobe. Store contents are not cleared;
// only entries that were pushed are ever read.

module double_ended_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [3:0]         func,
	input  wire logic signed [31:0] value,
	output logic                    strobe,
	output logic signed [31:0]      result_value,
	output logic [1:0]              status,
	output logic [4:0]              count,
	output logic                    is_empty,
	output logic                    last
);
	import dq_pkg::*;

	cmd_t fe_cmd;
	cmd_t be_cmd;
	res_t be_res;
	logic fe_push;
	logic q_full;
	logic q_valid;
	logic be_pop;

	// decode func and push the word into the command queue
	dq_front u_front (
		.start  (start),
		.func   (func),
		.value  (value),
		.q_full (q_full),
		.busy   (busy),
		.push   (fe_push),
		.cmd    (fe_cmd)
	);

	// lets the front keep accepting while a list or sort runs
	dq_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fe_push),
		.cmd_in  (fe_cmd),
		.pop     (be_pop),
		.valid   (q_valid),
		.full    (q_full),
		.cmd_out (be_cmd)
	);

	// store, ring pointers and the per-operation sequencer
	dq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.cmd     (be_cmd),
		.pop     (be_pop),
		.strobe  (strobe),
		.res     (be_res)
	);

	assign result_value = be_res.value;
	assign status       = be_res.status;
	assign count        = be_res.count;
	assign is_empty     = be_res.is_empty;
	assign last         = be_res.last;

	// a failed operation returns no value and closes its item
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != ST_OK) |-> (result_value == 32'sd0) && last)
		else $error("failed operation returned a value or left item open");

	// empty flag tracks the reported count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (is_empty == (count == 5'd0)))
		else $error("is_empty disagrees with count");

	// a push is refused only with the store at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_FULL) |-> (count == count5(CNT_W'(DEPTH))))
		else $error("full status with store not at capacity");

	// a list result that is not the last is followed right away by the next
	a_list_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a list run");

endmodule

`default_nettype wire
